// ----- design/gpu_command_word_parser_macros.svh -----
// Assertion macros shared by the command word parser modules.
// Defining ASSERT_OFF removes every assertion from the build.
`ifndef GPU_COMMAND_WORD_PARSER_MACROS_SVH
`define GPU_COMMAND_WORD_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every rising clock edge outside reset.
`define GCWP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A property that must hold at every rising clock edge outside reset whenever cond is true.
`define GCWP_ASSERT_IMPLIES(name, clk, rst_n, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`else

`define GCWP_ASSERT(name, clk, rst_n, prop, msg)
`define GCWP_ASSERT_IMPLIES(name, clk, rst_n, cond, prop, msg)

`endif

`endif

// ----- design/gcwp_pkg.sv -----
`timescale 1ns / 1ps

package gcwp_pkg;

  // Default width of the blit word counter.
  localparam int unsigned BLIT_COUNT_BITS_DEF = 19;
  // Width of a blit length as computed from a dims word (up to 2^18 words).
  localparam int unsigned BLIT_LEN_BITS = 20;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_GP0_WRITE = 2'd0,
    OP_GPUREAD   = 2'd1,
    OP_GP1       = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_ENV         = 3'd1,
    KIND_QUICK_FILL  = 3'd2,
    KIND_POLYGON     = 3'd3,
    KIND_RECTANGLE   = 3'd4,
    KIND_CPU_TO_VRAM = 3'd5,
    KIND_VRAM_TO_CPU = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    ROLE_NONE      = 4'd0,
    ROLE_COLOR     = 4'd1,
    ROLE_VERTEX    = 4'd2,
    ROLE_TEXCOORD  = 4'd3,
    ROLE_DIMS      = 4'd4,
    ROLE_SRC_POS   = 4'd5,
    ROLE_BLIT_DATA = 4'd6,
    ROLE_ENV       = 4'd7,
    ROLE_BLIT_READ = 4'd8
  } role_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_QF_POS     = 4'd1,
    PH_QF_DIMS    = 4'd2,
    PH_POLY_COLOR = 4'd3,
    PH_POLY_VERT  = 4'd4,
    PH_POLY_UV    = 4'd5,
    PH_RECT_POS   = 4'd6,
    PH_RECT_UV    = 4'd7,
    PH_RECT_DIMS  = 4'd8,
    PH_CV_SRC     = 4'd9,
    PH_CV_DIMS    = 4'd10,
    PH_CV_DATA    = 4'd11,
    PH_VC_SRC     = 4'd12,
    PH_VC_DIMS    = 4'd13,
    PH_VC_READ    = 4'd14
  } phase_e;

  // Command classes taken from the top three opcode bits.
  localparam logic [2:0] CLS_MISC        = 3'd0;
  localparam logic [2:0] CLS_POLYGON     = 3'd1;
  localparam logic [2:0] CLS_RECTANGLE   = 3'd3;
  localparam logic [2:0] CLS_CPU_TO_VRAM = 3'd5;
  localparam logic [2:0] CLS_VRAM_TO_CPU = 3'd6;
  localparam logic [2:0] CLS_ENV         = 3'd7;

  localparam logic [7:0] OPC_QUICK_FILL = 8'h02;
  localparam logic [7:0] OPC_ENV_FIRST  = 8'hE1;
  localparam logic [7:0] OPC_ENV_LAST   = 8'hE6;

  // Low opcode bits of the environment commands.
  localparam logic [2:0] ENV_TEXPAGE    = 3'd1;
  localparam logic [2:0] ENV_TEX_WINDOW = 3'd2;
  localparam logic [2:0] ENV_AREA_TL    = 3'd3;
  localparam logic [2:0] ENV_AREA_BR    = 3'd4;
  localparam logic [2:0] ENV_OFFSET     = 3'd5;
  localparam logic [2:0] ENV_MASK_BIT   = 3'd6;

  // GP1 get-info: opcodes 10h..1Fh, info index 2..5 selects E2..E5.
  localparam logic [3:0] GP1_INFO_OPC_HI = 4'h1;
  localparam logic [2:0] GP1_INFO_FIRST  = 3'd2;
  localparam logic [2:0] GP1_INFO_LAST   = 3'd5;

  localparam logic [31:0] READ_LATCH_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] word;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  command_kind;
    logic [3:0]  word_role;
    logic [1:0]  vertex_slot;
    logic [31:0] payload;
    logic        packet_done;
    logic [4:0]  primitive_flags;
    logic [1:0]  rect_size_code;
    logic [31:0] read_data;
    logic        vram_read_ready;
  } out_item_t;

  // Number of 32-bit words in a blit: ceil(w*h/2), where width wraps to
  // 1..1024 and height to 1..512.
  function automatic logic [BLIT_LEN_BITS-1:0] blit_len(input logic [31:0] dims);
    logic [9:0]  w_m1;
    logic [8:0]  h_m1;
    logic [10:0] w_pix;
    logic [9:0]  h_pix;
    logic [20:0] prod;
    logic [20:0] rounded;
    w_m1    = dims[9:0] - 10'd1;
    h_m1    = dims[24:16] - 9'd1;
    w_pix   = {1'b0, w_m1} + 11'd1;
    h_pix   = {1'b0, h_m1} + 10'd1;
    prod    = 21'(w_pix) * 21'(h_pix);
    rounded = (prod + 21'd1) >> 1;
    return rounded[BLIT_LEN_BITS-1:0];
  endfunction

endpackage

// ----- design/gcwp_in_stage.sv -----
`timescale 1ns / 1ps

module gcwp_in_stage
  import gcwp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  in_item_t data_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t data_o
);

  logic     valid_q, valid_d;
  in_item_t data_q;
  logic     load;

  // The register frees up in the same cycle its beat moves on.
  assign stall_o = valid_q && !advance_i;
  assign load    = valid_i && !stall_o;
  assign valid_d = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/gcwp_parser.sv -----
`timescale 1ns / 1ps
`include "gpu_command_word_parser_macros.svh"

module gcwp_parser
  import gcwp_pkg::*;
#(
  parameter int unsigned BLIT_COUNT_BITS = BLIT_COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  phase_e                     phase_q, phase_d;
  logic [1:0]                 vcount_q, vcount_d;
  logic [4:0]                 held_flags_q, held_flags_d;
  logic [1:0]                 held_rsz_q, held_rsz_d;
  logic [BLIT_COUNT_BITS-1:0] blit_left_q, blit_left_d;
  logic [31:0]                read_latch_q, read_latch_d;
  logic [21:0]                env_q [4];
  logic [21:0]                env_d [4];
  logic [15:0]                texpage_q, texpage_d;
  logic                       rd_ready_q, rd_ready_d;

  logic [7:0]                 opc;
  logic [BLIT_COUNT_BITS-1:0] blit_len_w;
  logic [BLIT_COUNT_BITS-1:0] blit_dec;
  logic [1:0]                 last_vertex;
  logic [1:0]                 env_sel;
  logic                       advance;
  logic                       blit_read;
  kind_e                      kind;
  role_e                      role;
  out_item_t                  res;

  assign opc         = item_i.word[31:24];
  assign blit_len_w  = BLIT_COUNT_BITS'(blit_len(item_i.word));
  assign blit_dec    = blit_left_q - BLIT_COUNT_BITS'(1);
  assign last_vertex = held_flags_q[3] ? 2'd3 : 2'd2;
  assign env_sel     = item_i.word[1:0] - GP1_INFO_FIRST[1:0];

  always_comb begin
    phase_d      = phase_q;
    vcount_d     = vcount_q;
    held_flags_d = held_flags_q;
    held_rsz_d   = held_rsz_q;
    blit_left_d  = blit_left_q;
    read_latch_d = read_latch_q;
    env_d        = env_q;
    texpage_d    = texpage_q;
    rd_ready_d   = rd_ready_q;
    advance      = 1'b0;
    blit_read    = 1'b0;
    kind         = KIND_NONE;
    role         = ROLE_NONE;
    res          = '0;

    unique case (op_e'(item_i.operation))
      OP_GP0_WRITE: begin
        res.accepted = 1'b1;
        unique case (phase_q)
          PH_IDLE: begin
            unique case (opc[7:5])
              CLS_MISC: begin
                if (opc == OPC_QUICK_FILL) begin
                  kind    = KIND_QUICK_FILL;
                  role    = ROLE_COLOR;
                  phase_d = PH_QF_POS;
                end else begin
                  res.accepted = 1'b0;
                end
              end
              CLS_POLYGON: begin
                held_flags_d = opc[4:0];
                vcount_d     = 2'd0;
                kind         = KIND_POLYGON;
                role         = ROLE_COLOR;
                phase_d      = PH_POLY_VERT;
              end
              CLS_RECTANGLE: begin
                held_flags_d = {2'b00, opc[2:0]};
                held_rsz_d   = opc[4:3];
                kind         = KIND_RECTANGLE;
                role         = ROLE_COLOR;
                phase_d      = PH_RECT_POS;
              end
              CLS_CPU_TO_VRAM: begin
                kind    = KIND_CPU_TO_VRAM;
                phase_d = PH_CV_SRC;
              end
              CLS_VRAM_TO_CPU: begin
                kind    = KIND_VRAM_TO_CPU;
                phase_d = PH_VC_SRC;
              end
              CLS_ENV: begin
                if (opc >= OPC_ENV_FIRST && opc <= OPC_ENV_LAST) begin
                  kind = KIND_ENV;
                  role = ROLE_ENV;
                  unique case (opc[2:0])
                    ENV_TEXPAGE:    texpage_d[13:0] = item_i.word[13:0];
                    ENV_TEX_WINDOW: env_d[0] = {2'b00, item_i.word[19:0]};
                    ENV_AREA_TL:    env_d[1] = {3'b000, item_i.word[18:0]};
                    ENV_AREA_BR:    env_d[2] = {3'b000, item_i.word[18:0]};
                    ENV_OFFSET:     env_d[3] = item_i.word[21:0];
                    ENV_MASK_BIT:   texpage_d[15:14] = item_i.word[1:0];
                    default:        texpage_d = texpage_q;
                  endcase
                end else begin
                  res.accepted = 1'b0;
                end
              end
              default: res.accepted = 1'b0;
            endcase
          end
          PH_QF_POS: begin
            kind    = KIND_QUICK_FILL;
            role    = ROLE_VERTEX;
            phase_d = PH_QF_DIMS;
          end
          PH_QF_DIMS: begin
            kind            = KIND_QUICK_FILL;
            role            = ROLE_DIMS;
            res.packet_done = 1'b1;
            phase_d         = PH_IDLE;
          end
          PH_POLY_COLOR, PH_POLY_VERT, PH_POLY_UV: begin
            kind            = KIND_POLYGON;
            res.vertex_slot = vcount_q;
            if (phase_q == PH_POLY_COLOR) begin
              role    = ROLE_COLOR;
              phase_d = PH_POLY_VERT;
            end else if (phase_q == PH_POLY_VERT) begin
              role = ROLE_VERTEX;
              if (held_flags_q[2]) begin
                phase_d = PH_POLY_UV;
              end else begin
                advance = 1'b1;
              end
            end else begin
              role    = ROLE_TEXCOORD;
              advance = 1'b1;
            end
            if (advance) begin
              if (vcount_q >= last_vertex) begin
                res.packet_done = 1'b1;
                phase_d         = PH_IDLE;
                vcount_d        = 2'd0;
              end else begin
                vcount_d = vcount_q + 2'd1;
                phase_d  = held_flags_q[4] ? PH_POLY_COLOR : PH_POLY_VERT;
              end
            end
          end
          PH_RECT_POS, PH_RECT_UV: begin
            kind = KIND_RECTANGLE;
            role = (phase_q == PH_RECT_POS) ? ROLE_VERTEX : ROLE_TEXCOORD;
            if (phase_q == PH_RECT_POS && held_flags_q[2]) begin
              phase_d = PH_RECT_UV;
            end else if (held_rsz_q == 2'd0) begin
              phase_d = PH_RECT_DIMS;
            end else begin
              res.packet_done = 1'b1;
              phase_d         = PH_IDLE;
            end
          end
          PH_RECT_DIMS: begin
            kind            = KIND_RECTANGLE;
            role            = ROLE_DIMS;
            res.packet_done = 1'b1;
            phase_d         = PH_IDLE;
          end
          PH_CV_SRC, PH_VC_SRC: begin
            kind    = (phase_q == PH_CV_SRC) ? KIND_CPU_TO_VRAM : KIND_VRAM_TO_CPU;
            role    = ROLE_SRC_POS;
            phase_d = (phase_q == PH_CV_SRC) ? PH_CV_DIMS : PH_VC_DIMS;
          end
          PH_CV_DIMS, PH_VC_DIMS: begin
            kind        = (phase_q == PH_CV_DIMS) ? KIND_CPU_TO_VRAM : KIND_VRAM_TO_CPU;
            role        = ROLE_DIMS;
            blit_left_d = blit_len_w;
            if (blit_len_w == '0) begin
              res.packet_done = 1'b1;
              phase_d         = PH_IDLE;
            end else if (phase_q == PH_CV_DIMS) begin
              phase_d = PH_CV_DATA;
            end else begin
              phase_d    = PH_VC_READ;
              rd_ready_d = 1'b1;
            end
          end
          PH_CV_DATA: begin
            kind        = KIND_CPU_TO_VRAM;
            role        = ROLE_BLIT_DATA;
            blit_left_d = blit_dec;
            if (blit_dec == '0) begin
              res.packet_done = 1'b1;
              phase_d         = PH_IDLE;
            end
          end
          default: begin
            // GP0 writes are ignored while the CPU drains a VRAM read.
            res.accepted = 1'b0;
            if (phase_q != PH_VC_READ) begin
              phase_d = PH_IDLE;
            end
          end
        endcase
      end
      OP_GPUREAD: begin
        if (phase_q == PH_VC_READ) begin
          blit_read   = 1'b1;
          kind        = KIND_VRAM_TO_CPU;
          role        = ROLE_BLIT_READ;
          blit_left_d = blit_dec;
          if (blit_dec == '0) begin
            res.packet_done = 1'b1;
            phase_d         = PH_IDLE;
            rd_ready_d      = 1'b0;
          end
        end
      end
      OP_GP1: begin
        if (opc[7:4] == GP1_INFO_OPC_HI && item_i.word[2:0] >= GP1_INFO_FIRST &&
            item_i.word[2:0] <= GP1_INFO_LAST) begin
          read_latch_d = {10'd0, env_q[env_sel]};
        end
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase

    res.command_kind = kind;
    res.word_role    = role;
    res.payload      = res.accepted ? item_i.word : 32'd0;
    if (kind == KIND_POLYGON || kind == KIND_RECTANGLE) begin
      res.primitive_flags = held_flags_d;
    end
    if (kind == KIND_RECTANGLE) begin
      res.rect_size_code = held_rsz_d;
    end
    res.read_data       = blit_read ? 32'd0 : read_latch_d;
    res.vram_read_ready = rd_ready_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      vcount_q     <= 2'd0;
      held_flags_q <= 5'd0;
      held_rsz_q   <= 2'd0;
      blit_left_q  <= '0;
      read_latch_q <= READ_LATCH_RESET;
      env_q        <= '{default: '0};
      texpage_q    <= 16'd0;
      rd_ready_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      vcount_q     <= vcount_d;
      held_flags_q <= held_flags_d;
      held_rsz_q   <= held_rsz_d;
      blit_left_q  <= blit_left_d;
      read_latch_q <= read_latch_d;
      env_q        <= env_d;
      texpage_q    <= texpage_d;
      rd_ready_q   <= rd_ready_d;
    end
  end

  assign result_o = res;

  `GCWP_ASSERT(a_ready_flag_tracks_phase, clk_i, rst_ni, rd_ready_q == (phase_q == PH_VC_READ), "read-ready flag disagrees with parse phase")
  `GCWP_ASSERT_IMPLIES(a_blit_count_live, clk_i, rst_ni, phase_q == PH_CV_DATA || phase_q == PH_VC_READ, blit_left_q != '0, "blit phase with no words left")
  `GCWP_ASSERT_IMPLIES(a_fourth_vertex_quad_only, clk_i, rst_ni, vcount_q == 2'd3, held_flags_q[3], "fourth vertex slot outside a quad")

endmodule

// ----- design/gpu_command_word_parser.sv -----
`timescale 1ns / 1ps
`include "gpu_command_word_parser_macros.svh"
// Channel   Direction  Signals                               Beat
// -------   ---------  ------------------------------------  ------------------------------
// in        input      in_valid_i, in_stall_o, in_data_i     operation and 32-bit word
// out       output     out_valid_o, out_stall_i, out_data_o  one tagged result per input
//
// Each input beat yields exactly one output beat, and a new beat is taken every
// cycle while the output is not stalled; the rate is set by the single pass from
// the input register through the parser logic into the result register.
// Reset is asynchronous and active low; no clearing pass follows it.
// A stall at the output holds the result register, and the input register
// stalls the input channel only when it is full and cannot hand its beat on.

module gpu_command_word_parser
  import gcwp_pkg::*;
#(
  parameter int unsigned BLIT_COUNT_BITS = BLIT_COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  logic      out_free;
  logic      item_valid;
  in_item_t  item;
  logic      fire;
  out_item_t result;

  // The result register can take a new beat when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = item_valid && out_free;

  gcwp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .data_i    (in_data_i),
    .advance_i (out_free),
    .valid_o   (item_valid),
    .data_o    (item)
  );

  // The parser commits its state only when the beat it works on moves into
  // the result register, so a stall never repeats or drops a state update.
  gcwp_parser #(
    .BLIT_COUNT_BITS (BLIT_COUNT_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `GCWP_ASSERT_IMPLIES(a_dropped_word_no_payload, clk_i, rst_ni, out_valid_o && !out_data_o.accepted, out_data_o.payload == 32'd0, "payload on a word that was not consumed")
  `GCWP_ASSERT_IMPLIES(a_done_has_kind, clk_i, rst_ni, out_valid_o && out_data_o.packet_done, out_data_o.command_kind != KIND_NONE, "packet end without a command kind")

endmodule

// ----- sim/gpu_command_word_parser_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the GP0/GP1 command word parser.
//
// A single sender task drives input beats, and it predicts the tagged result of
// every beat the block takes. A separate monitor compares each result beat, one
// field at a time, with the oldest prediction. A third process drives the result
// stall. The tests run one after another from the main initial block. First come
// short directed sequences that cover the odd single words, the environment
// latches, GP1 readback and one packet of each kind. Then come blits whose width
// and height wrap around, a long random stream of mostly well-formed packets,
// and a back-pressure phase in which the receiver holds off long enough to fill
// the block.

module gpu_command_word_parser_tb;
  import gcwp_pkg::*;

  // Width of the blit counter at the default parameter of the block.
  localparam int unsigned BLIT_BITS = BLIT_COUNT_BITS_DEF;
  // Length of the long receiver hold-off used to back the block up.
  localparam int unsigned HOLD_CYCLES = 150;
  // Opcode classes that the parser ignores and the package does not name.
  localparam logic [2:0] CLS_LINE = 3'd2;
  localparam logic [2:0] CLS_VRAM_COPY = 3'd4;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  gpu_command_word_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predicted tagged results, oldest first.
  out_item_t pending_results[$];
  int        mismatches = 0;
  // Words that did real work (consumed GP0 words and blit reads) in this phase.
  int        words_counted = 0;

  // The random gaps on each side can be turned off to get stretches at full rate.
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  // Set by the back-pressure test. The stall process clears it when the hold ends.
  bit hold_request = 1'b0;

  // The bench's own copy of the parser state, at its reset values.
  phase_e           cur_phase = PH_IDLE;
  logic [1:0]       vert_idx = '0;
  logic [4:0]       prim_flags_q = '0;
  logic [1:0]       rect_size_q = '0;
  logic [BLIT_BITS-1:0] blit_remaining = '0;
  logic [31:0]      gpuread_latch = READ_LATCH_RESET;
  logic [21:0]      env_regs [4] = '{default: '0};
  logic [15:0]      texpage_bits = '0;
  logic             vram_ready = 1'b0;

  // A blit of w by h pixels moves ceil(w*h/2) words. The width wraps into 1..1024
  // and the height into 1..512, so a zero field means the largest size.
  function automatic logic [BLIT_BITS-1:0] blit_words(input logic [31:0] dims);
    int unsigned cols;
    int unsigned rows;
    cols = ((32'(dims[15:0]) - 32'd1) & 32'h3FF) + 32'd1;
    rows = ((32'(dims[31:16]) - 32'd1) & 32'h1FF) + 32'd1;
    return BLIT_BITS'((cols * rows + 32'd1) >> 1);
  endfunction

  // Computes the tagged result of one input beat and advances the copy of
  // the parser state.
  function automatic out_item_t tag_command_word(input in_item_t beat);
    out_item_t  res;
    logic [7:0] opc;
    logic [1:0] last_vtx;
    logic [2:0] info_idx;
    logic       advance;
    logic       blit_read;
    res       = '0;
    opc       = beat.word[31:24];
    advance   = 1'b0;
    blit_read = 1'b0;
    case (beat.operation)
      OP_GP0_WRITE: begin
        res.accepted = 1'b1;
        case (cur_phase)
          PH_IDLE: begin
            case (opc[7:5])
              CLS_MISC: begin
                // Only quick fill starts a packet. Zero and other misc opcodes drop.
                if (opc == OPC_QUICK_FILL) begin
                  res.command_kind = KIND_QUICK_FILL;
                  res.word_role = ROLE_COLOR;
                  cur_phase = PH_QF_POS;
                end else begin
                  res.accepted = 1'b0;
                end
              end
              CLS_POLYGON: begin
                prim_flags_q = opc[4:0];
                vert_idx = '0;
                res.command_kind = KIND_POLYGON;
                res.word_role = ROLE_COLOR;
                cur_phase = PH_POLY_VERT;
              end
              CLS_RECTANGLE: begin
                prim_flags_q = {2'b00, opc[2:0]};
                rect_size_q = opc[4:3];
                res.command_kind = KIND_RECTANGLE;
                res.word_role = ROLE_COLOR;
                cur_phase = PH_RECT_POS;
              end
              CLS_CPU_TO_VRAM: begin
                res.command_kind = KIND_CPU_TO_VRAM;
                cur_phase = PH_CV_SRC;
              end
              CLS_VRAM_TO_CPU: begin
                res.command_kind = KIND_VRAM_TO_CPU;
                cur_phase = PH_VC_SRC;
              end
              CLS_ENV: begin
                if (opc >= OPC_ENV_FIRST && opc <= OPC_ENV_LAST) begin
                  res.command_kind = KIND_ENV;
                  res.word_role = ROLE_ENV;
                  case (opc[2:0])
                    ENV_TEXPAGE:    texpage_bits[13:0] = beat.word[13:0];
                    ENV_TEX_WINDOW: env_regs[0] = {2'b00, beat.word[19:0]};
                    ENV_AREA_TL:    env_regs[1] = {3'b000, beat.word[18:0]};
                    ENV_AREA_BR:    env_regs[2] = {3'b000, beat.word[18:0]};
                    ENV_OFFSET:     env_regs[3] = beat.word[21:0];
                    default:        texpage_bits[15:14] = beat.word[1:0];
                  endcase
                end else begin
                  res.accepted = 1'b0;
                end
              end
              default: res.accepted = 1'b0;
            endcase
          end
          PH_QF_POS: begin
            res.command_kind = KIND_QUICK_FILL;
            res.word_role = ROLE_VERTEX;
            cur_phase = PH_QF_DIMS;
          end
          PH_QF_DIMS: begin
            res.command_kind = KIND_QUICK_FILL;
            res.word_role = ROLE_DIMS;
            res.packet_done = 1'b1;
            cur_phase = PH_IDLE;
          end
          PH_POLY_COLOR, PH_POLY_VERT, PH_POLY_UV: begin
            res.command_kind = KIND_POLYGON;
            res.vertex_slot = vert_idx;
            if (cur_phase == PH_POLY_COLOR) begin
              res.word_role = ROLE_COLOR;
              cur_phase = PH_POLY_VERT;
            end else if (cur_phase == PH_POLY_VERT) begin
              res.word_role = ROLE_VERTEX;
              if (prim_flags_q[2]) cur_phase = PH_POLY_UV;
              else advance = 1'b1;
            end else begin
              res.word_role = ROLE_TEXCOORD;
              advance = 1'b1;
            end
            // A vertex is complete; move to the next one or close the packet.
            if (advance) begin
              last_vtx = prim_flags_q[3] ? 2'd3 : 2'd2;
              if (vert_idx >= last_vtx) begin
                res.packet_done = 1'b1;
                cur_phase = PH_IDLE;
                vert_idx = '0;
              end else begin
                vert_idx = vert_idx + 2'd1;
                cur_phase = prim_flags_q[4] ? PH_POLY_COLOR : PH_POLY_VERT;
              end
            end
          end
          PH_RECT_POS, PH_RECT_UV: begin
            res.command_kind = KIND_RECTANGLE;
            res.word_role = (cur_phase == PH_RECT_POS) ? ROLE_VERTEX : ROLE_TEXCOORD;
            if (cur_phase == PH_RECT_POS && prim_flags_q[2]) begin
              cur_phase = PH_RECT_UV;
            end else if (rect_size_q == 2'd0) begin
              cur_phase = PH_RECT_DIMS;
            end else begin
              res.packet_done = 1'b1;
              cur_phase = PH_IDLE;
            end
          end
          PH_RECT_DIMS: begin
            res.command_kind = KIND_RECTANGLE;
            res.word_role = ROLE_DIMS;
            res.packet_done = 1'b1;
            cur_phase = PH_IDLE;
          end
          PH_CV_SRC, PH_VC_SRC: begin
            res.command_kind = (cur_phase == PH_CV_SRC) ? KIND_CPU_TO_VRAM : KIND_VRAM_TO_CPU;
            res.word_role = ROLE_SRC_POS;
            cur_phase = (cur_phase == PH_CV_SRC) ? PH_CV_DIMS : PH_VC_DIMS;
          end
          PH_CV_DIMS, PH_VC_DIMS: begin
            res.command_kind = (cur_phase == PH_CV_DIMS) ? KIND_CPU_TO_VRAM : KIND_VRAM_TO_CPU;
            res.word_role = ROLE_DIMS;
            blit_remaining = blit_words(beat.word);
            if (blit_remaining == '0) begin
              res.packet_done = 1'b1;
              cur_phase = PH_IDLE;
            end else if (cur_phase == PH_CV_DIMS) begin
              cur_phase = PH_CV_DATA;
            end else begin
              cur_phase = PH_VC_READ;
              vram_ready = 1'b1;
            end
          end
          PH_CV_DATA: begin
            res.command_kind = KIND_CPU_TO_VRAM;
            res.word_role = ROLE_BLIT_DATA;
            blit_remaining = blit_remaining - BLIT_BITS'(1);
            if (blit_remaining == '0) begin
              res.packet_done = 1'b1;
              cur_phase = PH_IDLE;
            end
          end
          default: begin
            // A GP0 write while VRAM-to-CPU data is pending is ignored.
            res.accepted = 1'b0;
            if (cur_phase != PH_VC_READ) cur_phase = PH_IDLE;
          end
        endcase
        if (res.command_kind == KIND_POLYGON || res.command_kind == KIND_RECTANGLE)
          res.primitive_flags = prim_flags_q;
        if (res.command_kind == KIND_RECTANGLE) res.rect_size_code = rect_size_q;
        if (res.accepted) res.payload = beat.word;
      end
      OP_GPUREAD: begin
        if (cur_phase == PH_VC_READ) begin
          blit_read = 1'b1;
          res.command_kind = KIND_VRAM_TO_CPU;
          res.word_role = ROLE_BLIT_READ;
          blit_remaining = blit_remaining - BLIT_BITS'(1);
          if (blit_remaining == '0) begin
            res.packet_done = 1'b1;
            cur_phase = PH_IDLE;
            vram_ready = 1'b0;
          end
        end
      end
      OP_GP1: begin
        // Get-info copies one of the E2..E5 latches into the GPUREAD latch.
        if (opc[7:4] == GP1_INFO_OPC_HI) begin
          info_idx = beat.word[2:0];
          if (info_idx >= GP1_INFO_FIRST && info_idx <= GP1_INFO_LAST)
            gpuread_latch = {10'd0, env_regs[info_idx - GP1_INFO_FIRST]};
        end
      end
      default: ;
    endcase
    res.read_data = blit_read ? 32'd0 : gpuread_latch;
    res.vram_read_ready = vram_ready;
    return res;
  endfunction

  // Most idle stretches are short, and a few are much longer.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Dims for a random blit. Most are small, but now and then the width or the
  // height field is zero so that it wraps to its largest value. The bits that
  // the size ignores are random.
  function automatic logic [31:0] random_blit_dims();
    logic [9:0] wf;
    logic [8:0] hf;
    int         r;
    r  = $urandom_range(0, 99);
    wf = 10'($urandom_range(1, 16));
    hf = 9'($urandom_range(1, 8));
    if (r < 3) begin
      wf = '0;
      hf = 9'd1;
    end else if (r < 5) begin
      wf = 10'd1;
      hf = '0;
    end
    return {7'($urandom), hf, 6'($urandom), wf};
  endfunction

  // Drives one beat at the falling edge and waits for it to be taken. Then it
  // records the prediction. The beat is taken at the rising edge where the input
  // stall is low, so the state copy advances in the same order as the block.
  task automatic push_beat(input op_e op, input logic [31:0] word);
    in_item_t  beat;
    out_item_t want;
    int        gap;
    beat.operation = op;
    beat.word = word;
    gap = (sender_idles && $urandom_range(0, 1) == 1) ? idle_length() : 0;
    if (gap > 0) begin
      // While valid is low, the data lines carry junk that must not be used.
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_data_i <= {2'($urandom), 32'($urandom)};
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = tag_command_word(beat);
    pending_results.push_back(want);
    if (want.accepted || want.word_role == ROLE_BLIT_READ) words_counted++;
  endtask

  // A packet word. Now and then a stray read, GP1 request or empty beat is put
  // in front of it, so that these show up in the middle of a packet as well.
  task automatic send_content(input logic [31:0] word);
    if ($urandom_range(0, 19) == 0) push_beat(op_e'($urandom_range(1, 3)), $urandom);
    push_beat(OP_GP0_WRITE, word);
  endtask

  // Completes an unfinished packet so that the next one starts from idle. This
  // is only used after draw packets, where any word is packet content, and after
  // VRAM-to-CPU blits, which need reads.
  task automatic settle_parser();
    while (cur_phase != PH_IDLE) begin
      if (cur_phase == PH_VC_READ) push_beat(OP_GPUREAD, $urandom);
      else push_beat(OP_GP0_WRITE, $urandom);
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with nothing expected, actual 0x%0h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.accepted !== want.accepted)
      report_field("accepted", 32'(want.accepted), 32'(got.accepted));
    if (got.command_kind !== want.command_kind)
      report_field("command_kind", 32'(want.command_kind), 32'(got.command_kind));
    if (got.word_role !== want.word_role)
      report_field("word_role", 32'(want.word_role), 32'(got.word_role));
    if (got.vertex_slot !== want.vertex_slot)
      report_field("vertex_slot", 32'(want.vertex_slot), 32'(got.vertex_slot));
    if (got.payload !== want.payload)
      report_field("payload", want.payload, got.payload);
    if (got.packet_done !== want.packet_done)
      report_field("packet_done", 32'(want.packet_done), 32'(got.packet_done));
    if (got.primitive_flags !== want.primitive_flags)
      report_field("primitive_flags", 32'(want.primitive_flags),
                   32'(got.primitive_flags));
    if (got.rect_size_code !== want.rect_size_code)
      report_field("rect_size_code", 32'(want.rect_size_code), 32'(got.rect_size_code));
    if (got.read_data !== want.read_data)
      report_field("read_data", want.read_data, got.read_data);
    if (got.vram_read_ready !== want.vram_read_ready)
      report_field("vram_read_ready", 32'(want.vram_read_ready),
                   32'(got.vram_read_ready));
  endtask

  // Mostly well-formed packets with random content, mixed with single words,
  // GP1 requests, reads, ignored opcodes and packets cut short. It stops once
  // target words have done real work.
  task automatic run_packets(input int target, input bit vary_idling);
    int          pick;
    int          n;
    logic [31:0] cmd;
    logic [31:0] dims;
    logic [2:0]  cls;
    words_counted = 0;
    while (words_counted < target) begin
      settle_parser();
      if (vary_idling && $urandom_range(0, 19) == 0) begin
        sender_idles = 1'($urandom_range(0, 1));
        receiver_idles = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_content({OPC_QUICK_FILL, 24'($urandom)});
        send_content($urandom);
        send_content($urandom);
      end else if (pick < 35) begin
        // Opcode bit 4 is gouraud, bit 3 is quad and bit 2 is textured.
        cmd = {CLS_POLYGON, 29'($urandom)};
        send_content(cmd);
        for (int v = 0; v < (cmd[27] ? 4 : 3); v++) begin
          if (v > 0 && cmd[28]) send_content($urandom);
          send_content($urandom);
          if (cmd[26]) send_content($urandom);
        end
      end else if (pick < 55) begin
        cmd = {CLS_RECTANGLE, 29'($urandom)};
        send_content(cmd);
        send_content($urandom);
        if (cmd[26]) send_content($urandom);
        if (cmd[28:27] == 2'd0) send_content($urandom);
      end else if (pick < 63) begin
        send_content({CLS_CPU_TO_VRAM, 29'($urandom)});
        send_content($urandom);
        dims = random_blit_dims();
        send_content(dims);
        n = int'(blit_words(dims));
        repeat (n) send_content($urandom);
      end else if (pick < 71) begin
        send_content({CLS_VRAM_TO_CPU, 29'($urandom)});
        send_content($urandom);
        dims = random_blit_dims();
        send_content(dims);
        n = int'(blit_words(dims));
        // Writes, GP1 requests and empty beats between the reads must not
        // disturb the blit.
        while (n > 0) begin
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
              0:       push_beat(OP_GP0_WRITE, $urandom);
              1:       push_beat(OP_GP1, {GP1_INFO_OPC_HI, 28'($urandom)});
              default: push_beat(OP_NONE, $urandom);
            endcase
          end else begin
            push_beat(OP_GPUREAD, $urandom);
            n--;
          end
        end
      end else if (pick < 81) begin
        if ($urandom_range(0, 4) != 0)
          cmd = {8'($urandom_range(OPC_ENV_FIRST, OPC_ENV_LAST)), 24'($urandom)};
        else
          cmd = {CLS_ENV, 29'($urandom)};
        push_beat(OP_GP0_WRITE, cmd);
      end else if (pick < 87) begin
        if ($urandom_range(0, 3) != 0) push_beat(OP_GP1, {GP1_INFO_OPC_HI, 28'($urandom)});
        else push_beat(OP_GP1, $urandom);
      end else if (pick < 91) begin
        push_beat(OP_GPUREAD, $urandom);
      end else if (pick < 94) begin
        push_beat(OP_NONE, $urandom);
      end else if (pick < 97) begin
        // Opcodes the parser has no packet for. Class zero may still hit quick
        // fill, and the settle step then completes that packet.
        case ($urandom_range(0, 2))
          0:       cls = CLS_MISC;
          1:       cls = CLS_LINE;
          default: cls = CLS_VRAM_COPY;
        endcase
        push_beat(OP_GP0_WRITE, {cls, 29'($urandom)});
      end else begin
        // A draw packet cut short. The settle step fills it with random words.
        case ($urandom_range(0, 2))
          0:       cmd = {OPC_QUICK_FILL, 24'($urandom)};
          1:       cmd = {CLS_POLYGON, 29'($urandom)};
          default: cmd = {CLS_RECTANGLE, 29'($urandom)};
        endcase
        push_beat(OP_GP0_WRITE, cmd);
        repeat ($urandom_range(0, 2)) push_beat(OP_GP0_WRITE, $urandom);
      end
    end
  endtask

  // After reset a read returns the all-ones latch, and an empty beat does nothing.
  task automatic test_reset_state();
    push_beat(OP_GPUREAD, 32'h0000_0000);
    push_beat(OP_NONE, 32'hFFFF_FFFF);
    push_beat(OP_GPUREAD, 32'hFFFF_FFFF);
  endtask

  // Single words: dropped and ignored opcodes, every environment latch filled
  // with all ones to expose its mask, and GP1 readback for every info index.
  task automatic test_single_words();
    push_beat(OP_GP0_WRITE, 32'h0000_0000);
    push_beat(OP_GP0_WRITE, {CLS_MISC, 29'h01FF_FFFF});
    push_beat(OP_GP0_WRITE, {CLS_LINE, 29'h1FFF_FFFF});
    push_beat(OP_GP0_WRITE, {CLS_VRAM_COPY, 29'h1F00_0000});
    push_beat(OP_GP0_WRITE, {CLS_ENV, 29'h0000_0000});
    push_beat(OP_GP0_WRITE, {CLS_ENV, 29'h0FFF_FFFF});
    for (int e = int'(OPC_ENV_FIRST); e <= int'(OPC_ENV_LAST); e++)
      push_beat(OP_GP0_WRITE, {8'(e), 24'hFF_FFFF});
    for (int idx = 0; idx < 8; idx++)
      push_beat(OP_GP1, {GP1_INFO_OPC_HI, 4'(idx * 2), 21'd0, 3'(idx)});
    push_beat(OP_GP1, 32'hFF00_0003);
  endtask

  // One packet of each kind: quick fill, variable and fixed rectangles, a flat
  // textured triangle, and two small blits. A write and a GP1 request come before
  // the VRAM-to-CPU reads, and an empty beat falls between those reads.
  task automatic test_packet_shapes();
    push_beat(OP_GP0_WRITE, {OPC_QUICK_FILL, 24'hFF_FFFF});
    push_beat(OP_GP0_WRITE, 32'h0000_0000);
    push_beat(OP_GP0_WRITE, 32'hFFFF_FFFF);
    push_beat(OP_GP0_WRITE, {CLS_RECTANGLE, 29'h0000_0000});
    push_beat(OP_GP0_WRITE, 32'h0001_0001);
    push_beat(OP_GP0_WRITE, 32'h0010_0010);
    push_beat(OP_GP0_WRITE, {CLS_RECTANGLE, 29'h1FFF_FFFF});
    push_beat(OP_GP0_WRITE, 32'hFFFF_FFFF);
    push_beat(OP_GP0_WRITE, 32'h0000_0000);
    push_beat(OP_GP0_WRITE, {CLS_POLYGON, 5'b00101, 24'h12_3456});
    repeat (6) push_beat(OP_GP0_WRITE, $urandom);
    push_beat(OP_GP0_WRITE, {CLS_CPU_TO_VRAM, 29'h0000_0000});
    push_beat(OP_GP0_WRITE, 32'h0000_0000);
    push_beat(OP_GP0_WRITE, 32'h0001_0001);
    push_beat(OP_GP0_WRITE, 32'hFFFF_FFFF);
    push_beat(OP_GP0_WRITE, {CLS_VRAM_TO_CPU, 29'h1FFF_FFFF});
    push_beat(OP_GP0_WRITE, 32'hFFFF_FFFF);
    push_beat(OP_GP0_WRITE, 32'h0002_0002);
    push_beat(OP_GP0_WRITE, {CLS_POLYGON, 29'h0});
    push_beat(OP_GP1, {GP1_INFO_OPC_HI, 25'd0, GP1_INFO_LAST});
    push_beat(OP_GPUREAD, 32'd0);
    push_beat(OP_NONE, 32'd0);
    push_beat(OP_GPUREAD, 32'd0);
  endtask

  // A zero width field wraps to 1024 pixels and a zero height field to 512. The
  // bits that the size ignores are set in the second blit.
  task automatic test_blit_extents();
    push_beat(OP_GP0_WRITE, {CLS_CPU_TO_VRAM, 29'h1FFF_FFFF});
    push_beat(OP_GP0_WRITE, $urandom);
    push_beat(OP_GP0_WRITE, 32'h0001_0000);
    repeat (blit_words(32'h0001_0000)) push_beat(OP_GP0_WRITE, $urandom);
    push_beat(OP_GP0_WRITE, {CLS_VRAM_TO_CPU, 29'h0000_0000});
    push_beat(OP_GP0_WRITE, $urandom);
    push_beat(OP_GP0_WRITE, 32'hFE00_FC01);
    settle_parser();
  endtask

  task automatic test_random_stream();
    run_packets(600, 1'b1);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender offers beats at
  // full rate. The block has to fill up and stall its input without losing a beat.
  task automatic test_backpressure();
    sender_idles = 1'b0;
    hold_request = 1'b1;
    run_packets(60, 1'b0);
    sender_idles = 1'b1;
  endtask

  // Result stall. Short random stalls while enabled, and one long hold-off on
  // request that is counted out here.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_request = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 99) < 30) begin
        n = idle_length();
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result monitor. A beat moves at a rising edge with valid high and stall low.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    end
  end

  // A hung handshake ends the run here.
  initial begin
    #(20_000_000);
    $display("[gpu_command_word_parser] ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_single_words();
    test_packet_shapes();
    test_blit_extents();
    test_random_stream();
    test_backpressure();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Give any extra result beat time to show up and be caught.
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[gpu_command_word_parser] OK");
    end else begin
      $display("[gpu_command_word_parser] ERROR");
    end
    $finish;
  end

endmodule
